/* hw/rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic [1:0]  status;
  } rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/rau_if.sv */
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface rau_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// Accept requests, sign-extend operands and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_front #(
  parameter int OPERAND_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  rau_req_if.sink            req,
  output rau_pkg::req_t      q_data,
  output logic               q_valid,
  input  wire logic          q_pop
);
  rau_pkg::req_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  function automatic logic [31:0] sx(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int i = OPERAND_BITS; i < 32; i++) r[i] = v[OPERAND_BITS-1];
    return r;
  endfunction

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{req.kind, sx(req.a_num), sx(req.a_den), sx(req.b_num), sx(req.b_den)};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |-> !req.ready)
    else $error("ready while full");
endmodule
`default_nettype wire

/* hw/rtl/rau_back.sv */
// ----------------------------------------------------------------------------
// rau_back
// Form products, combine sums and differences, reduce those by a shift-subtract Euclid gcd, emit result.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rau_pkg::req_t q_data,
  input  wire logic          q_valid,
  output logic               q_pop,
  rau_rsp_if.source          rsp
);
  rau_pkg::back_state_t state, state_next;
  rau_pkg::req_t        cur;
  logic signed [63:0]   p, q, d;
  logic [63:0]          nm, dm, ga, gb, divq, rem, dvs;
  logic                 nneg;
  logic [6:0]           cnt;
  logic [64:0]          trial;
  logic [63:0]          rem_sh;
  logic [63:0]          pm, qm, dmag;
  logic                 pn, qn;

  always_comb begin
    pn   = p[63];
    qn   = q[63] ^ (cur.kind == rau_pkg::KIND_SUB);
    pm   = p[63] ? 64'd0 - p : p;
    qm   = q[63] ? 64'd0 - q : q;
    dmag = d[63] ? 64'd0 - d : d;
  end

  // one restoring-division step: rem/divq shift
  always_comb begin
    rem_sh = {rem[62:0], divq[63]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE: if (q_valid) state_next = rau_pkg::S_MUL;
      rau_pkg::S_MUL:  state_next = rau_pkg::S_SUM;
      rau_pkg::S_SUM:
        if (cur.kind == rau_pkg::KIND_MUL || cur.kind == rau_pkg::KIND_DIV || d == 64'sd0)
          state_next = rau_pkg::S_DONE;
        else state_next = rau_pkg::S_GCD;
      rau_pkg::S_GCD:  if (gb == 64'd0) state_next = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN: if (cnt == 7'd64) state_next = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD: if (cnt == 7'd64) state_next = rau_pkg::S_DONE;
      rau_pkg::S_DONE: if (rsp.ready) state_next = rau_pkg::S_IDLE;
      default:         state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == rau_pkg::S_IDLE) && q_valid;
    rsp.valid = (state == rau_pkg::S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        rau_pkg::S_IDLE: if (q_valid) cur <= q_data;
        rau_pkg::S_MUL: begin
          if (cur.kind == rau_pkg::KIND_MUL) begin
            p <= 64'($signed(cur.a_num)) * 64'($signed(cur.b_num));
            q <= '0;
          end else if (cur.kind == rau_pkg::KIND_DIV) begin
            p <= 64'($signed(cur.a_num)) * 64'($signed(cur.b_den));
            q <= '0;
          end else begin
            p <= 64'($signed(cur.a_num)) * 64'($signed(cur.b_den));
            q <= 64'($signed(cur.b_num)) * 64'($signed(cur.a_den));
          end
          if (cur.kind == rau_pkg::KIND_DIV)
            d <= 64'($signed(cur.a_den)) * 64'($signed(cur.b_num));
          else
            d <= 64'($signed(cur.a_den)) * 64'($signed(cur.b_den));
        end
        rau_pkg::S_SUM: begin
          if (cur.kind == rau_pkg::KIND_MUL || cur.kind == rau_pkg::KIND_DIV) begin
            rsp.res_num <= p;
            rsp.res_den <= d;
            rsp.status  <= (d == 64'sd0) ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK;
          end else begin
            logic [63:0] n;
            logic        ng;
            if (pn == qn) begin n = pm + qm; ng = pn; end
            else if (pm >= qm) begin n = pm - qm; ng = pn; end
            else begin n = qm - pm; ng = qn; end
            if (n == 64'd0) ng = 1'b0;
            if (d == 64'sd0) begin
              rsp.res_num <= ng ? 64'd0 - n : n;
              rsp.res_den <= '0;
              rsp.status  <= rau_pkg::ST_ZERO_DEN;
            end else begin
              nm   <= n;
              dm   <= dmag;
              ga   <= n;
              gb   <= dmag;
              nneg <= (d[63] && n != 64'd0) ? ~ng : ng;
              cnt  <= '0;
              rem  <= '0;
            end
          end
        end
        rau_pkg::S_GCD: begin
          if (gb != 64'd0) begin
            // iterated Euclid step with one remainder bit per cycle
            if (cnt == 7'd0) begin
              divq <= ga; dvs <= gb; rem <= '0; cnt <= 7'd1;
            end else if (cnt <= 7'd64) begin
              divq <= {divq[62:0], 1'b0};
              rem  <= trial[64] ? rem_sh : trial[63:0];
              cnt  <= cnt + 7'd1;
            end else begin
              ga <= gb; gb <= rem; cnt <= '0;
            end
          end else begin
            divq <= nm; dvs <= ga; rem <= '0; cnt <= '0;
          end
        end
        rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
          if (cnt == 7'd64) begin
            if (state == rau_pkg::S_DIVN) begin
              nm <= divq; divq <= dm; rem <= '0;
            end else begin
              dm <= divq;
              rsp.res_num <= nneg ? 64'd0 - nm : nm;
              rsp.res_den <= divq;
              rsp.status  <= (!nneg && nm[63]) ? rau_pkg::ST_OVERFLOW : rau_pkg::ST_OK;
            end
            cnt <= '0;
          end else begin
            divq <= {divq[62:0], ~trial[64]};
            rem  <= trial[64] ? rem_sh : trial[63:0];
            cnt  <= cnt + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |=> !rsp.valid)
    else $error("result shown while loading");
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.res_num))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) cnt <= 7'd66)
    else $error("step counter out of range");
endmodule
`default_nettype wire

/* hw/rtl/rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Add, subtract, multiply, divide fractions; sums reduced by Euclid gcd.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | kind, a_num, a_den, b_num, b_den
// rsp     | out | res_num, res_den, status
// Multiply/divide results are not reduced. Add/subtract run the Euclid steps of
// the gcd (one remainder bit a cycle), then divide the numerator and the
// denominator by it.
// Requests queue two deep in front while the back end iterates.
// Synchronous reset empties the queue and idles the back end.
`default_nettype none
module rational_arithmetic_unit_top #(
  parameter int OPERAND_BITS = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);
  rau_pkg::req_t q_data;
  logic          q_valid, q_pop;

  rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
    .clk, .rst, .req, .q_data, .q_valid, .q_pop
  );
  rau_back u_back (.clk, .rst, .q_data, .q_valid, .q_pop, .rsp);
endmodule
`default_nettype wire

/* tb/tb_rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_top
// Self-checking bench for the fraction add/subtract/multiply/divide unit.
// Directed operand extremes and zero denominators come first. Random
// requests follow, under phases of sender gaps and receiver stalls. Each
// result is checked field by field against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ITEMS       = 1300;
  localparam int  PHASE_ITEMS = ITEMS / 4;
  localparam longint LIMIT    = 60000000;

  class fraction_scoreboard;
    rau_pkg::rsp_t expected_q[$];
    int   mismatches;
    int   checked;

    function longint unsigned magnitude(longint v, output bit neg);
      neg = v < 0;
      return neg ? 64'd0 - v : v;
    endfunction

    function rau_pkg::rsp_t predict(rau_pkg::req_t r);
      longint an, ad, bn, bd, n, d;
      longint unsigned pm, qm, dm, nm, x, y, t;
      bit pneg, qneg, dneg, nneg;
      rau_pkg::rsp_t e;
      an = $signed(r.a_num);
      ad = $signed(r.a_den);
      bn = $signed(r.b_num);
      bd = $signed(r.b_den);
      e.status = rau_pkg::ST_OK;
      if (r.kind == rau_pkg::KIND_MUL || r.kind == rau_pkg::KIND_DIV) begin
        if (r.kind == rau_pkg::KIND_MUL) begin
          n = an * bn;
          d = ad * bd;
        end else begin
          n = an * bd;
          d = ad * bn;
        end
        e.res_num = n;
        e.res_den = d;
        if (d == 0) e.status = rau_pkg::ST_ZERO_DEN;
        return e;
      end
      pm = magnitude(an * bd, pneg);
      qm = magnitude(bn * ad, qneg);
      dm = magnitude(ad * bd, dneg);
      if (r.kind == rau_pkg::KIND_SUB) qneg = !qneg;
      if (pneg == qneg) begin
        nm = pm + qm;
        nneg = pneg;
      end else if (pm >= qm) begin
        nm = pm - qm;
        nneg = pneg;
      end else begin
        nm = qm - pm;
        nneg = qneg;
      end
      if (nm == 0) nneg = 0;
      if (dm == 0) begin
        e.res_num = nneg ? 64'd0 - nm : nm;
        e.res_den = 0;
        e.status = rau_pkg::ST_ZERO_DEN;
        return e;
      end
      if (dneg && nm != 0) nneg = !nneg;
      x = nm;
      y = dm;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nm = nm / x;
      dm = dm / x;
      e.res_num = nneg ? 64'd0 - nm : nm;
      e.res_den = dm;
      if (!nneg && nm >= 64'h8000_0000_0000_0000) e.status = rau_pkg::ST_OVERFLOW;
      return e;
    endfunction

    function void note_request(rau_pkg::req_t r);
      expected_q.push_back(predict(r));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(rau_pkg::rsp_t got);
      rau_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result num=%h den=%h st=%0d",
                         got.res_num, got.res_den, got.status));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.res_num !== e.res_num)
        report($sformatf("res_num %h, want %h", got.res_num, e.res_num));
      if (got.res_den !== e.res_den)
        report($sformatf("res_den %h, want %h", got.res_den, e.res_den));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  logic   clk;
  logic   rst;
  int     idle_mode;
  int     hold_off;
  longint cycles;
  int     sent;
  int     zero_dens;
  fraction_scoreboard sb;

  rau_req_if req_ch();
  rau_rsp_if rsp_ch();

  rational_arithmetic_unit_top uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand(bit wide);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3, 4, 5: return $urandom_range(0, 40) - 20;
      6, 7: return $signed(16'($urandom));
      default: begin
        if (wide || $urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 2000) - 1000;
      end
    endcase
  endfunction

  function automatic rau_pkg::req_t random_request();
    rau_pkg::req_t r;
    bit wide;
    r.kind = 2'($urandom_range(0, 3));
    wide = (r.kind == rau_pkg::KIND_MUL || r.kind == rau_pkg::KIND_DIV);
    r.a_num = pick_operand(wide);
    r.a_den = pick_operand(wide);
    r.b_num = pick_operand(wide);
    r.b_den = pick_operand(wide);
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready = 0;
    end else if (hold_off > 0) begin
      rsp_ch.ready = 0;
      hold_off = hold_off - 1;
    end else begin
      case (idle_mode)
        2: rsp_ch.ready = $urandom_range(0, 99) >= 70;
        3: rsp_ch.ready = $urandom_range(0, 99) >= 31;
        default: rsp_ch.ready = 1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_ch.status == rau_pkg::ST_ZERO_DEN) zero_dens++;
      sb.check_result('{rsp_ch.res_num, rsp_ch.res_den, rsp_ch.status});
    end
  end

  task send_request(rau_pkg::req_t r);
    int gap;
    gap = 0;
    if (idle_mode == 1)
      while ($urandom_range(0, 99) < 70) gap++;
    else if (idle_mode == 3)
      while ($urandom_range(0, 99) < 31) gap++;
    if (gap > 0) begin
      req_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1;
    req_ch.kind  = r.kind;
    req_ch.a_num = r.a_num;
    req_ch.a_den = r.a_den;
    req_ch.b_num = r.b_num;
    req_ch.b_den = r.b_den;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  task drain();
    req_ch.valid = 0;
    while (sb.pending() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] ext[5];
    sb = new();
    cycles = 0;
    sent = 0;
    zero_dens = 0;
    hold_off = 0;
    idle_mode = 0;
    rst = 1;
    req_ch.valid = 0;
    req_ch.kind  = rau_pkg::KIND_ADD;
    req_ch.a_num = 0;
    req_ch.a_den = 0;
    req_ch.b_num = 0;
    req_ch.b_den = 0;
    rsp_ch.ready = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
    for (int k = 0; k < 4; k++) begin
      send_request('{k[1:0], ext[0], ext[0], ext[0], ext[0]});
      send_request('{k[1:0], ext[1], ext[0], ext[0], ext[1]});
      send_request('{k[1:0], ext[4], ext[1], ext[1], ext[4]});
      send_request('{k[1:0], ext[2], ext[3], ext[2], ext[4]});
      send_request('{k[1:0], ext[3], ext[2], ext[1], ext[2]});
    end
    send_request('{rau_pkg::KIND_ADD, 32'd3, 32'd0, 32'd5, 32'd7});
    send_request('{rau_pkg::KIND_SUB, 32'd2, 32'd4, 32'd1, 32'd2});
    send_request('{rau_pkg::KIND_ADD, 32'd1, -32'sd2, 32'd1, -32'sd3});
    send_request('{rau_pkg::KIND_DIV, 32'd5, 32'd3, 32'd0, 32'd9});

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == PHASE_ITEMS / 2) hold_off = 400;
        send_request(random_request());
      end
      if (ph == 1) drain();
    end
    drain();
    repeat (300) @(posedge clk);

    $display("%0d requests sent, %0d results checked (%0d zero denominators)",
             sent, sb.checked, zero_dens);
    $display("all four operations, extreme operands and stall phases exercised");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("simulation failed");
    end
    $finish;
  end
endmodule
